// ----- design/assert_macros.svh -----
// assertion macros shared by the playout conditioner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define JBPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("jbpc property violated");
// condition must never be seen outside reset
`define JBPC_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("jbpc forbidden condition seen");
`else
`define JBPC_ASSERT(lbl, clk, rst_n, prop)
`define JBPC_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ----- design/jbpc_pkg.sv -----
// shared constants and types of the playout conditioner
package jbpc_pkg;

    // default structural parameters
    localparam int FRAME_SAMPLES_DEF = 256;
    localparam int FIFO_DEPTH_DEF    = 16384;
    localparam int XFADE_LEN_DEF     = 48;
    localparam int DRIFT_DIVISOR_DEF = 80;
    localparam int MAX_CHANNELS_DEF  = 2;

    // field widths
    localparam int SAMPLE_W = 25;
    localparam int IN_W     = 32;
    localparam int RAMP_W   = 24;
    localparam int RATE_W   = 16;
    localparam int TARGET_W = 13;
    localparam int CHAN_W   = 2;
    localparam int CNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 120;
    localparam int M_TUSER_W  = 3;

    // sample full scale, q1.23
    localparam logic signed [SAMPLE_W-1:0] FULL_SCALE = 25'sd8388608;

    // register reset values
    localparam logic [RATE_W-1:0]   FADE_IN_RST  = 16'd655;
    localparam logic [RATE_W-1:0]   FADE_OUT_RST = 16'd655;
    localparam logic [TARGET_W-1:0] TARGET_RST   = 13'd2880;
    localparam logic [CHAN_W-1:0]   CHAN_RST     = 2'd2;
    localparam logic [CHAN_W-1:0]   CHAN_MONO    = 2'd1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_IN  = 2'd0,
        CFG_FADE_OUT = 2'd1,
        CFG_TARGET   = 2'd2,
        CFG_CHANNELS = 2'd3
    } t_cfg_idx;

    // playout mode of an output frame
    typedef enum logic [1:0] {
        PM_PREFILL = 2'd0,
        PM_NORMAL  = 2'd1,
        PM_PARTIAL = 2'd2,
        PM_TAIL    = 2'd3
    } t_play_mode;

endpackage

// ----- design/jitter_buffer_playout_conditioner.sv -----
// Stereo playout jitter buffer: a push request (tuser 0) stores one clamped stereo frame in
// the sample ram, or counts an overrun when the buffer is full. A pull request (tuser 1)
// yields one output sample pair. The first sample of an output frame first passes drift
// discard and the mode decision; prefill silence then goes straight to the output register,
// other samples pass ramp update and gain and, in normal play with a running drift
// crossfade, the blend. The input is ready again in the cycle the result is presented,
// unless an earlier result is still waiting at the output. The sequencer handles gain and
// crossfade one channel at a time. Prefill, underrun and fade modes are reported on tuser
// with a first-sample flag. Configuration writes must only be issued while no pull request
// is in progress.
`include "assert_macros.svh"

module jitter_buffer_playout_conditioner #(
    parameter int FRAME_SAMPLES = jbpc_pkg::FRAME_SAMPLES_DEF,
    parameter int FIFO_DEPTH    = jbpc_pkg::FIFO_DEPTH_DEF,
    parameter int XFADE_LEN     = jbpc_pkg::XFADE_LEN_DEF,
    parameter int DRIFT_DIVISOR = jbpc_pkg::DRIFT_DIVISOR_DEF,
    parameter int MAX_CHANNELS  = jbpc_pkg::MAX_CHANNELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [jbpc_pkg::S_TDATA_W-1:0]   i_s_tdata,  // left_in[31:0], right_in[63:32]
    input  logic                             i_s_tuser,  // kind
    // output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // left_out[24:0], right_out[49:25], underrun_count[81:50], overrun_count[113:82], zeros
    output logic [jbpc_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic [jbpc_pkg::M_TUSER_W-1:0]   o_m_tuser,  // play_mode[1:0], frame_first[2]
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [jbpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [jbpc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import jbpc_pkg::*;

    localparam int AW       = $clog2(FIFO_DEPTH);
    localparam int FILL_W   = $clog2(FIFO_DEPTH + 1);
    localparam int POS_W    = $clog2(FRAME_SAMPLES);
    localparam int HAVE_W   = $clog2(FRAME_SAMPLES);
    localparam int CMP_W    = ((FILL_W > TARGET_W + 2) ? FILL_W : TARGET_W + 2) + 1;
    localparam int MIN_TGT  = 3 * FRAME_SAMPLES;
    localparam int DROP_MAX = FRAME_SAMPLES / DRIFT_DIVISOR + 1;
    localparam int XF_W     = $clog2(XFADE_LEN + 1);
    localparam int XD       = XFADE_LEN + 1;
    localparam int COEF_W   = $clog2(XD + 1);
    localparam int VM_W     = SAMPLE_W - 1 + COEF_W;
    localparam int V_W      = VM_W + 1;
    localparam int DATA_W   = 2 * SAMPLE_W;
    localparam logic [VM_W:0] RECIP = (VM_W + 1)'((64'd1 << VM_W) / XD);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_DRIFT = 13'b0000000000010,
        S_BEGIN = 13'b0000000000100,
        S_MODE  = 13'b0000000001000,
        S_RAMP  = 13'b0000000010000,
        S_STEP  = 13'b0000000100000,
        S_GAIN  = 13'b0000001000000,
        S_GFIN  = 13'b0000010000000,
        S_XMUL  = 13'b0000100000000,
        S_XREC  = 13'b0001000000000,
        S_XFIN  = 13'b0010000000000,
        S_UPD   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state                      r_state;
    logic [RATE_W-1:0]           r_fade_in, r_fade_out;
    logic [TARGET_W-1:0]         r_target;
    logic [CHAN_W-1:0]           r_chan;
    logic [AW-1:0]               r_wptr, r_rptr;
    logic [FILL_W-1:0]           r_fill;
    logic                        r_prefilled;
    logic [RAMP_W-1:0]           r_ramp;
    logic signed [SAMPLE_W-1:0]  r_held_l, r_held_r;
    logic [XF_W-1:0]             r_xfade;
    logic [POS_W-1:0]            r_pos;
    t_play_mode                  r_frame_mode, r_mode;
    logic [HAVE_W-1:0]           r_have;
    logic [CNT_W-1:0]            r_underruns, r_overruns;
    logic                        r_first, r_pop_ok, r_ch;
    logic [RATE_W+RAMP_W:0]      r_prod;
    logic signed [SAMPLE_W-1:0]  r_sl, r_sr, r_l, r_r;
    logic [2*RAMP_W-1:0]         r_gprod;
    logic                        r_gneg, r_vneg;
    logic [VM_W-1:0]             r_vmag, r_q;
    logic                        r_m_valid;
    logic [M_TDATA_W-1:0]        r_m_data;
    logic [M_TUSER_W-1:0]        r_m_user;

    logic                        in_acc, push_acc, push_ok, stereo, out_load;
    logic signed [IN_W-1:0]      in_l, in_r;
    logic signed [SAMPLE_W-1:0]  clamp_l, clamp_r;
    logic [CMP_W-1:0]            tgt_eff, fill_x, excess, drop;
    logic                        drift_hit;
    logic [AW:0]                 rp_sum, rp_drop;
    logic [AW-1:0]               rptr_inc, wptr_inc;
    t_play_mode                  mode_now;
    logic                        ram_re;
    logic [DATA_W-1:0]           ram_wdata, ram_rdata;
    logic signed [SAMPLE_W-1:0]  g_src;
    logic [RAMP_W-1:0]           g_mag, g_res;
    logic signed [SAMPLE_W-1:0]  g_val;
    logic signed [V_W-1:0]       x_o, x_h, x_co, x_ch, x_v;
    logic [VM_W+COEF_W-1:0]      x_back;
    logic [VM_W-1:0]             x_rem, x_q;
    logic signed [SAMPLE_W-1:0]  x_val;
    logic [2*VM_W:0]             x_rprod;

    // handshake and channel mode
    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign push_acc   = in_acc && !i_s_tuser;
    assign push_ok    = push_acc && (r_fill < FILL_W'(FIFO_DEPTH));
    assign stereo     = (MAX_CHANNELS > 1) && (r_chan != CHAN_MONO);
    assign out_load   = (r_state == S_OUT) && (!r_m_valid || i_m_tready);

    // input clamp to full scale
    assign in_l = signed'(i_s_tdata[IN_W-1:0]);
    assign in_r = signed'(i_s_tdata[2*IN_W-1:IN_W]);
    always_comb begin
        if (in_l > IN_W'(FULL_SCALE))       clamp_l = FULL_SCALE;
        else if (in_l < -IN_W'(FULL_SCALE)) clamp_l = -FULL_SCALE;
        else                                clamp_l = SAMPLE_W'(in_l);
        if (in_r > IN_W'(FULL_SCALE))       clamp_r = FULL_SCALE;
        else if (in_r < -IN_W'(FULL_SCALE)) clamp_r = -FULL_SCALE;
        else                                clamp_r = SAMPLE_W'(in_r);
    end
    assign ram_wdata = {clamp_r, clamp_l};

    // pointer increments
    assign wptr_inc = (r_wptr == AW'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign rptr_inc = (r_rptr == AW'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;

    // drift discard arithmetic
    assign tgt_eff   = (r_target < TARGET_W'(MIN_TGT)) ? CMP_W'(MIN_TGT) : CMP_W'(r_target);
    assign fill_x    = CMP_W'(r_fill);
    assign drift_hit = r_prefilled && (fill_x > CMP_W'(3) * tgt_eff);
    assign excess    = fill_x - CMP_W'(2) * tgt_eff;
    assign drop      = (excess < CMP_W'(DROP_MAX)) ? excess : CMP_W'(DROP_MAX);
    assign rp_sum    = (AW + 1)'(r_rptr) + (AW + 1)'(drop);
    assign rp_drop   = (rp_sum >= (AW + 1)'(FIFO_DEPTH)) ? rp_sum - (AW + 1)'(FIFO_DEPTH)
                                                         : rp_sum;

    // partial play falls to the fade tail once its frames are used up
    assign mode_now = (r_frame_mode == PM_PARTIAL && r_have == '0) ? PM_TAIL : r_frame_mode;
    assign ram_re   = (r_state == S_MODE) && (mode_now == PM_NORMAL || mode_now == PM_PARTIAL)
                      && (r_fill != '0);

    // gain multiply operands
    assign g_src = r_ch ? r_sr : r_sl;
    assign g_mag = RAMP_W'((g_src < 0) ? -g_src : g_src);
    assign g_res = r_gprod[2*RAMP_W-1:RAMP_W];
    assign g_val = r_gneg ? -SAMPLE_W'(g_res) : SAMPLE_W'(g_res);

    // crossfade blend and reciprocal divide by the blend length
    assign x_o     = V_W'(r_ch ? r_r : r_l);
    assign x_h     = V_W'(r_ch ? r_held_r : r_held_l);
    assign x_co    = V_W'(COEF_W'(XD) - COEF_W'(r_xfade));
    assign x_ch    = V_W'(r_xfade);
    assign x_v     = x_o * x_co + x_h * x_ch;
    assign x_rprod = (2 * VM_W + 1)'(r_vmag) * (2 * VM_W + 1)'(RECIP);
    assign x_back  = (VM_W + COEF_W)'(r_q) * (VM_W + COEF_W)'(XD);
    assign x_rem   = r_vmag - VM_W'(x_back);
    assign x_q     = (x_rem >= VM_W'(XD)) ? r_q + 1'b1 : r_q;
    assign x_val   = r_vneg ? -SAMPLE_W'(x_q) : SAMPLE_W'(x_q);

    jbpc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (push_ok),
        .i_waddr (r_wptr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rptr),
        .o_rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_in  <= FADE_IN_RST;
            r_fade_out <= FADE_OUT_RST;
            r_target   <= TARGET_RST;
            r_chan     <= CHAN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FADE_IN:  r_fade_in  <= i_cfg_data[RATE_W-1:0];
                CFG_FADE_OUT: r_fade_out <= i_cfg_data[RATE_W-1:0];
                CFG_TARGET:   r_target   <= i_cfg_data[TARGET_W-1:0];
                CFG_CHANNELS: r_chan     <= i_cfg_data[CHAN_W-1:0];
                default:      r_chan     <= r_chan;
            endcase
        end
    end

    // sequencer and buffer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_wptr       <= '0;
            r_rptr       <= '0;
            r_fill       <= '0;
            r_prefilled  <= 1'b0;
            r_ramp       <= '0;
            r_held_l     <= '0;
            r_held_r     <= '0;
            r_xfade      <= '0;
            r_pos        <= '0;
            r_frame_mode <= PM_PREFILL;
            r_mode       <= PM_PREFILL;
            r_have       <= '0;
            r_underruns  <= '0;
            r_overruns   <= '0;
            r_first      <= 1'b0;
            r_pop_ok     <= 1'b0;
            r_ch         <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (push_acc) begin
                        if (push_ok) begin
                            r_wptr <= wptr_inc;
                            r_fill <= r_fill + 1'b1;
                        end else begin
                            r_overruns <= r_overruns + 1'b1;
                        end
                    end else if (in_acc) begin
                        r_first <= (r_pos == '0);
                        r_state <= (r_pos == '0) ? S_DRIFT : S_MODE;
                    end
                end
                S_DRIFT: begin
                    if (drift_hit) begin
                        r_rptr  <= AW'(rp_drop);
                        r_fill  <= r_fill - FILL_W'(drop);
                        r_xfade <= XF_W'(XFADE_LEN);
                    end
                    r_state <= S_BEGIN;
                end
                S_BEGIN: begin
                    if (!r_prefilled && r_fill < FILL_W'(MIN_TGT)) begin
                        r_frame_mode <= PM_PREFILL;
                    end else begin
                        if (!r_prefilled) begin
                            r_prefilled <= 1'b1;
                            r_ramp      <= '0;
                        end
                        if (r_fill < FILL_W'(FRAME_SAMPLES)) begin
                            r_underruns  <= r_underruns + 1'b1;
                            r_have       <= HAVE_W'(r_fill);
                            r_frame_mode <= (r_fill != '0) ? PM_PARTIAL : PM_TAIL;
                        end else begin
                            r_frame_mode <= PM_NORMAL;
                        end
                    end
                    r_state <= S_MODE;
                end
                S_MODE: begin
                    r_frame_mode <= mode_now;
                    r_mode       <= mode_now;
                    r_pop_ok     <= ram_re;
                    r_ch         <= 1'b0;
                    if (ram_re) begin
                        r_rptr <= rptr_inc;
                        r_fill <= r_fill - 1'b1;
                    end
                    r_state <= (mode_now == PM_PREFILL) ? S_OUT : S_RAMP;
                end
                S_RAMP: begin
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (r_mode == PM_TAIL) begin
                        r_ramp <= r_ramp - RAMP_W'(r_prod >> RATE_W);
                    end else begin
                        r_ramp <= r_ramp + RAMP_W'(r_prod >> RATE_W);
                    end
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_state <= S_GFIN;
                end
                S_GFIN: begin
                    if (!r_ch && stereo) begin
                        r_ch    <= 1'b1;
                        r_state <= S_GAIN;
                    end else if (r_mode == PM_TAIL) begin
                        r_state <= S_OUT;
                    end else if (r_mode == PM_NORMAL && r_xfade != '0) begin
                        r_ch    <= 1'b0;
                        r_state <= S_XMUL;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_XMUL: begin
                    r_state <= S_XREC;
                end
                S_XREC: begin
                    r_state <= S_XFIN;
                end
                S_XFIN: begin
                    if (!r_ch && stereo) begin
                        r_ch    <= 1'b1;
                        r_state <= S_XMUL;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_held_l <= r_l;
                    if (stereo) begin
                        r_held_r <= r_r;
                    end
                    if (r_mode == PM_NORMAL && r_xfade != '0) begin
                        r_xfade <= r_xfade - 1'b1;
                    end
                    if (r_mode == PM_PARTIAL) begin
                        r_have <= r_have - 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_pos   <= (r_pos == POS_W'(FRAME_SAMPLES - 1)) ? '0 : r_pos + 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MODE: begin
                r_l <= '0;
                r_r <= '0;
            end
            S_RAMP: begin
                if (r_mode == PM_TAIL) begin
                    r_prod <= (RATE_W + RAMP_W + 1)'(r_ramp) * (RATE_W + RAMP_W + 1)'(r_fade_out);
                    r_sl   <= r_held_l;
                    r_sr   <= r_held_r;
                end else begin
                    r_prod <= (RATE_W + RAMP_W + 1)'(r_fade_in)
                              * ((RATE_W + RAMP_W + 1)'(1) << RAMP_W)
                              - (RATE_W + RAMP_W + 1)'(r_fade_in) * (RATE_W + RAMP_W + 1)'(r_ramp);
                    r_sl   <= r_pop_ok ? signed'(ram_rdata[SAMPLE_W-1:0]) : '0;
                    r_sr   <= r_pop_ok ? signed'(ram_rdata[DATA_W-1:SAMPLE_W]) : '0;
                end
            end
            S_GAIN: begin
                r_gprod <= (2 * RAMP_W)'(g_mag) * (2 * RAMP_W)'(r_ramp);
                r_gneg  <= (g_src < 0);
            end
            S_GFIN: begin
                if (r_ch) r_r <= g_val;
                else      r_l <= g_val;
            end
            S_XMUL: begin
                r_vneg <= (x_v < 0);
                r_vmag <= VM_W'((x_v < 0) ? -x_v : x_v);
            end
            S_XREC: begin
                r_q <= VM_W'(x_rprod >> VM_W);
            end
            S_XFIN: begin
                if (r_ch) r_r <= x_val;
                else      r_l <= x_val;
            end
            default: begin
                r_q <= r_q;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= {6'd0, r_overruns, r_underruns,
                         stereo ? r_r : SAMPLE_W'(0), r_l};
            r_m_user <= {r_first, r_mode};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // checks
    `JBPC_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= FILL_W'(FIFO_DEPTH))
    `JBPC_ASSERT(a_push_count, i_clk, i_rst_n, push_ok |=> r_fill == $past(r_fill) + 1'b1)
    `JBPC_ASSERT(a_fade_in_up, i_clk, i_rst_n,
        (r_state == S_STEP && r_mode != PM_TAIL) |=> r_ramp >= $past(r_ramp))
    `JBPC_NEVER(a_prefill_sticky, i_clk, i_rst_n, $fell(r_prefilled))

endmodule

// ----- design/jbpc_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
module jbpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the playout conditioner: stream driver, result monitor, predictor
`timescale 1ns / 1ps

module tb_top;
    import jbpc_pkg::*;

    localparam int FRAME   = 256;
    localparam int DEPTH   = 16384;
    localparam int XLEN    = 48;
    localparam int DROP_MAX = FRAME / 80 + 1;
    localparam int SETTLE  = 40;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        bit          pull;
        logic [31:0] l;
        logic [31:0] r;
    } t_request;

    typedef struct {
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;
        t_play_mode                 mode;
        bit                         first;
        logic [CNT_W-1:0]           under;
        logic [CNT_W-1:0]           over;
    } t_sample_out;

    logic                  i_clk, i_rst_n;
    logic                  i_s_tvalid, o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid, i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic [M_TUSER_W-1:0]  o_m_tuser;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    jitter_buffer_playout_conditioner i_dut (.*);

    // pending requests, expected samples, run flags
    t_request    pending_q[$];
    t_sample_out sample_q[$];
    int  failures;
    bit  quiet, hold_req, hold_started, in_taken;
    int  in_gap, out_gap, hold_cnt, stall_cycles;

    // predictor state and register copy
    int          buf_l[DEPTH];
    int          buf_r[DEPTH];
    int unsigned wr_ptr, rd_ptr, fill;
    bit          primed;
    int unsigned ramp;
    int          held_l, held_r;
    int unsigned xfade_cnt, pos, remain, n_under, n_over;
    t_play_mode  fmode;
    int unsigned rate_in, rate_out, tgt, chans;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clamp_sample(logic [31:0] v);
        int x;
        x = int'(v);
        if (x > 8388608) x = 8388608;
        if (x < -8388608) x = -8388608;
        return x;
    endfunction

    function automatic int scale(int s, int unsigned g);
        longint m;
        m = (s < 0) ? -longint'(s) : longint'(s);
        m = (m * longint'(g)) >>> 24;
        return (s < 0) ? int'(-m) : int'(m);
    endfunction

    function automatic int blend(int o, int h, int unsigned x);
        longint v;
        v = longint'(o) * (XLEN + 1 - longint'(x)) + longint'(h) * longint'(x);
        return int'(v / (XLEN + 1));
    endfunction

    // frame boundary: drift discard then mode decision
    function automatic void start_frame();
        int unsigned t, drop;
        t = (tgt < 3 * FRAME) ? 3 * FRAME : tgt;
        if (primed && fill > 3 * t) begin
            drop = DROP_MAX;
            if (drop > fill - 2 * t) drop = fill - 2 * t;
            rd_ptr = (rd_ptr + drop) % DEPTH;
            fill -= drop;
            xfade_cnt = XLEN;
        end
        if (!primed) begin
            if (fill < 3 * FRAME) begin
                fmode = PM_PREFILL;
                return;
            end
            primed = 1'b1;
            ramp = 0;
        end
        if (fill < FRAME) begin
            n_under++;
            remain = fill;
            fmode = (remain > 0) ? PM_PARTIAL : PM_TAIL;
        end else begin
            fmode = PM_NORMAL;
        end
    endfunction

    // one pull request: work out the output sample
    function automatic t_sample_out play_sample();
        t_sample_out e;
        int l, r, sl, sr;
        bit st;
        l = 0;
        r = 0;
        sl = 0;
        sr = 0;
        e.first = (pos == 0);
        if (e.first) start_frame();
        st = (chans != CHAN_MONO);
        if (fmode == PM_PARTIAL && remain == 0) fmode = PM_TAIL;
        if (fmode == PM_NORMAL || fmode == PM_PARTIAL) begin
            if (fill > 0) begin
                sl = buf_l[rd_ptr];
                sr = buf_r[rd_ptr];
                rd_ptr = (rd_ptr + 1) % DEPTH;
                fill--;
            end
            ramp += int'((longint'(rate_in) * (longint'(1) << 24) - longint'(rate_in) * ramp)
                         >>> 16);
            l = scale(sl, ramp);
            if (st) r = scale(sr, ramp);
            if (fmode == PM_NORMAL && xfade_cnt > 0) begin
                l = blend(l, held_l, xfade_cnt);
                if (st) r = blend(r, held_r, xfade_cnt);
                xfade_cnt--;
            end
            held_l = l;
            if (st) held_r = r;
            if (fmode == PM_PARTIAL) remain--;
        end else if (fmode == PM_TAIL) begin
            ramp -= int'((longint'(ramp) * longint'(rate_out)) >>> 16);
            l = scale(held_l, ramp);
            if (st) r = scale(held_r, ramp);
        end
        if (!st) r = 0;
        pos = (pos + 1) % FRAME;
        e.l = l[SAMPLE_W-1:0];
        e.r = r[SAMPLE_W-1:0];
        e.mode = fmode;
        e.under = n_under;
        e.over = n_over;
        return e;
    endfunction

    // input side: predict on every accepted request
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_s_tvalid && o_s_tready;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            if (i_s_tuser) begin
                sample_q.push_back(play_sample());
            end else if (fill >= DEPTH) begin
                n_over++;
            end else begin
                buf_l[wr_ptr] = clamp_sample(i_s_tdata[31:0]);
                buf_r[wr_ptr] = clamp_sample(i_s_tdata[63:32]);
                wr_ptr = (wr_ptr + 1) % DEPTH;
                fill++;
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_request rq;
        if (!i_rst_n || (i_s_tvalid && !in_taken)) begin
        end else if (in_gap > 0) begin
            in_gap--;
            i_s_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
            if (!quiet && $urandom_range(0, 15) == 0) begin
                in_gap = $urandom_range(1, 13);
                i_s_tvalid <= 1'b0;
            end else begin
                rq = pending_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= rq.pull;
                i_s_tdata  <= {rq.r, rq.l};
            end
        end else begin
            i_s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge i_clk) begin
        if (hold_req && !hold_started) begin
            hold_started = 1'b1;
            hold_cnt = HOLD_CYCLES;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_m_tready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 15) == 0) begin
            out_gap = $urandom_range(1, 13);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_sample_out e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (sample_q.size() == 0) begin
                $error("output sample with nothing expected");
                failures++;
            end else begin
                e = sample_q.pop_front();
                if (o_m_tdata[24:0] !== e.l) begin
                    $error("left_out exp %0d got %0d", e.l, $signed(o_m_tdata[24:0]));
                    failures++;
                end
                if (o_m_tdata[49:25] !== e.r) begin
                    $error("right_out exp %0d got %0d", e.r, $signed(o_m_tdata[49:25]));
                    failures++;
                end
                if (o_m_tdata[81:50] !== e.under) begin
                    $error("underrun_count exp %0d got %0d", e.under, o_m_tdata[81:50]);
                    failures++;
                end
                if (o_m_tdata[113:82] !== e.over) begin
                    $error("overrun_count exp %0d got %0d", e.over, o_m_tdata[113:82]);
                    failures++;
                end
                if (o_m_tuser[1:0] !== e.mode) begin
                    $error("play_mode exp %0d got %0d", e.mode, o_m_tuser[1:0]);
                    failures++;
                end
                if (o_m_tuser[2] !== e.first) begin
                    $error("frame_first exp %0d got %0d", e.first, o_m_tuser[2]);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("jitter_buffer_playout_conditioner verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sd8388608 : -32'sd8388608;
            default: return int'($urandom_range(0, 16777216)) - 8388608;
        endcase
    endfunction

    task automatic add_request(bit pull);
        t_request rq;
        rq.pull = pull;
        rq.l = rand_sample();
        rq.r = rand_sample();
        pending_q.push_back(rq);
    endtask

    // random mix, push share in percent
    task automatic add_mix(int n, int push_pct);
        repeat (n) add_request($urandom_range(0, 99) >= push_pct);
    endtask

    task automatic add_pushes(int n);
        repeat (n) add_request(1'b0);
    endtask

    // wait until the block has drained and gone quiet
    task automatic drain();
        while (pending_q.size() > 0 || i_s_tvalid || sample_q.size() > 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_FADE_IN:  rate_in  = val;
            CFG_FADE_OUT: rate_out = val;
            CFG_TARGET:   tgt      = val[TARGET_W-1:0];
            CFG_CHANNELS: chans    = val[CHAN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_regs(int fi, int fo, int t, int ch);
        write_reg(CFG_FADE_IN, CFG_DATA_W'(fi));
        write_reg(CFG_FADE_OUT, CFG_DATA_W'(fo));
        write_reg(CFG_TARGET, CFG_DATA_W'(t));
        write_reg(CFG_CHANNELS, CFG_DATA_W'(ch));
    endtask

    // stimulus
    initial begin
        t_request rq;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_FADE_IN;
        i_cfg_data = '0;
        failures = 0;
        rate_in = FADE_IN_RST;
        rate_out = FADE_OUT_RST;
        tgt = TARGET_RST;
        chans = CHAN_RST;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: pull while empty opens a prefill frame, then extreme samples
        add_request(1'b1);
        rq.pull = 1'b0;
        rq.l = 32'h7fffffff; rq.r = 32'h80000000; pending_q.push_back(rq);
        rq.l = 32'h00800000; rq.r = 32'hff800000; pending_q.push_back(rq);
        rq.l = 32'h00800001; rq.r = 32'hff7fffff; pending_q.push_back(rq);
        rq.l = 32'h007fffff; rq.r = 32'h00000000; pending_q.push_back(rq);
        rq.l = 32'hffffffff; rq.r = 32'h00000001; pending_q.push_back(rq);
        rq.l = 32'haaaaaaaa; rq.r = 32'h55555555; pending_q.push_back(rq);
        // rest of the prefill frame while the buffer fills past the prefill mark
        repeat (FRAME - 1) begin
            add_request(1'b1);
            add_pushes(3);
        end
        drain();

        // low target, mono, sharp fade-in: normal play starts
        set_regs(65535, 0, 768, 1);
        add_mix(30, 40);
        drain();

        // odd channel code, random rates, long receiver hold-off
        set_regs($urandom_range(1, 65534), $urandom_range(1, 65534), 768, 0);
        hold_req = 1'b1;
        add_mix(40, 50);
        drain();
        write_reg(CFG_CHANNELS, CFG_DATA_W'(3));
        add_mix(30, 50);
        drain();

        // final part without idling
        set_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                 $urandom_range(768, 5461), 2);
        quiet = 1'b1;
        add_mix(40, 30);
        drain();

        if (failures == 0)
            $display("jitter_buffer_playout_conditioner verification clean");
        else
            $display("jitter_buffer_playout_conditioner verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/jbpc_pkg.sv
design/jbpc_ram.sv
design/jitter_buffer_playout_conditioner.sv
tb/sv/tb_top.sv
